@@ rtl/llta_pkg.sv @@
// llta_pkg: shared constants for the least loaded task assigner.
// No dependencies; used by the interfaces and every rtl module.
package llta_pkg;

    // default parameter values for the top level
    localparam int DEF_MAX_WORKERS   = 16;
    localparam int DEF_DURATION_BITS = 16;
    localparam int DEF_LOAD_BITS     = 24;

    // fixed field widths
    localparam int CFG_W          = 5;   // workers_in_use register
    localparam int WORKER_FIELD_W = 4;   // chosen_worker result field

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index, taken from paddr[2] (word address)
    typedef enum logic {
        REG_WORKERS_IN_USE = 1'b0,
        REG_UNUSED         = 1'b1
    } t_reg_idx;

    localparam logic [CFG_W-1:0] WORKERS_RESET = 5'd2;

    // front-to-back task queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

endpackage

@@ rtl/llta_if.sv @@
// llta_if: valid/ready channel interfaces for tasks and results.
// Depends on llta_pkg for default widths.

interface llta_task_if #(
    parameter int DURATION_BITS = llta_pkg::DEF_DURATION_BITS
);
    logic                     valid;
    logic                     ready;
    logic [DURATION_BITS-1:0] duration;
    logic                     last_of_job;

    modport source (output valid, duration, last_of_job, input ready);
    modport sink   (input valid, duration, last_of_job, output ready);
endinterface

interface llta_result_if #(
    parameter int LOAD_BITS = llta_pkg::DEF_LOAD_BITS
);
    logic                                  valid;
    logic                                  ready;
    logic [llta_pkg::WORKER_FIELD_W-1:0]   chosen_worker;
    logic [LOAD_BITS-1:0]                  worker_finish;
    logic [LOAD_BITS-1:0]                  makespan;
    logic                                  overflow;

    modport source (output valid, chosen_worker, worker_finish, makespan, overflow,
                    input ready);
    modport sink   (input valid, chosen_worker, worker_finish, makespan, overflow,
                    output ready);
endinterface

@@ rtl/llta_front.sv @@
// llta_front: accepts task items into a short queue ahead of the scheduler.
// Depends on llta_pkg (queue depth and pointer widths).
module llta_front #(
    parameter int DURATION_BITS = llta_pkg::DEF_DURATION_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [DURATION_BITS-1:0] i_duration,
    input  logic                     i_last,
    output logic                     o_q_valid,
    output logic [DURATION_BITS-1:0] o_q_duration,
    output logic                     o_q_last,
    input  logic                     i_q_pop
);

    logic [DURATION_BITS-1:0] r_dur  [llta_pkg::QUEUE_DEPTH];
    logic                     r_last [llta_pkg::QUEUE_DEPTH];
    logic [llta_pkg::QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [llta_pkg::QUEUE_CNT_W-1:0] r_count, n_count;
    logic push;

    assign o_ready      = (r_count != llta_pkg::QUEUE_CNT_W'(llta_pkg::QUEUE_DEPTH));
    assign push         = i_valid && o_ready;
    assign o_q_valid    = (r_count != '0);
    assign o_q_duration = r_dur[r_rd_ptr];
    assign o_q_last     = r_last[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // payload storage, no reset
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_dur[r_wr_ptr]  <= i_duration;
            r_last[r_wr_ptr] <= i_last;
        end
    end

endmodule

@@ rtl/llta_back.sv @@
// llta_back: per-worker load table, least-load choice, saturating add and
// makespan, with a registered result stage. Depends on llta_pkg.
module llta_back #(
    parameter int MAX_WORKERS   = llta_pkg::DEF_MAX_WORKERS,
    parameter int DURATION_BITS = llta_pkg::DEF_DURATION_BITS,
    parameter int LOAD_BITS     = llta_pkg::DEF_LOAD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [llta_pkg::CFG_W-1:0]          i_workers,
    input  logic                                i_q_valid,
    input  logic [DURATION_BITS-1:0]            i_q_duration,
    input  logic                                i_q_last,
    output logic                                o_q_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [llta_pkg::WORKER_FIELD_W-1:0] o_chosen_worker,
    output logic [LOAD_BITS-1:0]                o_worker_finish,
    output logic [LOAD_BITS-1:0]                o_makespan,
    output logic                                o_overflow
);

    localparam int IDX_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int NLEAF  = 1 << IDX_W;
    localparam int SUM_W  = ((LOAD_BITS > DURATION_BITS) ? LOAD_BITS : DURATION_BITS) + 1;
    localparam int WF_W   = llta_pkg::WORKER_FIELD_W;

    logic [LOAD_BITS-1:0] r_load [MAX_WORKERS];

    // comparison tree: level 0 holds the leaves, level IDX_W the root
    logic [LOAD_BITS-1:0] t_min [IDX_W+1][NLEAF];
    logic [IDX_W-1:0]     t_idx [IDX_W+1][NLEAF];
    logic                 t_ok  [IDX_W+1][NLEAF];
    logic [LOAD_BITS-1:0] t_max [IDX_W+1][NLEAF];

    logic [IDX_W-1:0]        best;
    logic [SUM_W-1:0]        sum;
    logic                    ovf;
    logic [LOAD_BITS-1:0]    new_load;
    logic [LOAD_BITS-1:0]    span;
    logic [IDX_W+WF_W-1:0]   best_wide;
    logic                    any_load;

    always_comb begin
        for (int i = 0; i < NLEAF; i++) begin
            if (i < MAX_WORKERS) begin
                t_min[0][i] = r_load[i];
                // worker 0 always takes tasks, even with a zero count
                t_ok[0][i]  = (i == 0) || (i < int'(i_workers));
            end else begin
                t_min[0][i] = '0;
                t_ok[0][i]  = 1'b0;
            end
            t_idx[0][i] = IDX_W'(i);
            t_max[0][i] = t_ok[0][i] ? t_min[0][i] : '0;
        end
        for (int k = 1; k <= IDX_W; k++) begin
            for (int j = 0; j < NLEAF; j++) begin
                t_min[k][j] = '0;
                t_idx[k][j] = '0;
                t_ok[k][j]  = 1'b0;
                t_max[k][j] = '0;
            end
            for (int j = 0; j < NLEAF / 2; j++) begin
                // right side wins only when strictly smaller: lowest index on a tie
                if (t_ok[k-1][2*j+1] &&
                    (!t_ok[k-1][2*j] || (t_min[k-1][2*j+1] < t_min[k-1][2*j]))) begin
                    t_min[k][j] = t_min[k-1][2*j+1];
                    t_idx[k][j] = t_idx[k-1][2*j+1];
                end else begin
                    t_min[k][j] = t_min[k-1][2*j];
                    t_idx[k][j] = t_idx[k-1][2*j];
                end
                t_ok[k][j]  = t_ok[k-1][2*j] || t_ok[k-1][2*j+1];
                t_max[k][j] = (t_max[k-1][2*j+1] > t_max[k-1][2*j]) ?
                              t_max[k-1][2*j+1] : t_max[k-1][2*j];
            end
        end
    end

    assign best     = t_idx[IDX_W][0];
    assign sum      = SUM_W'(t_min[IDX_W][0]) + SUM_W'(i_q_duration);
    assign ovf      = |sum[SUM_W-1:LOAD_BITS];
    assign new_load = ovf ? {LOAD_BITS{1'b1}} : sum[LOAD_BITS-1:0];
    // loads only grow, so the new makespan is the old one or the new load
    assign span     = (new_load > t_max[IDX_W][0]) ? new_load : t_max[IDX_W][0];
    assign best_wide = {{WF_W{1'b0}}, best};

    assign o_q_pop = i_q_valid && (!o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            for (int w = 0; w < MAX_WORKERS; w++) begin
                r_load[w] <= '0;
            end
        end else begin
            if (o_q_pop) begin
                o_valid <= 1'b1;
                for (int w = 0; w < MAX_WORKERS; w++) begin
                    if (i_q_last) begin
                        r_load[w] <= '0;
                    end else if (IDX_W'(w) == best) begin
                        r_load[w] <= new_load;
                    end
                end
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            o_chosen_worker <= best_wide[WF_W-1:0];
            o_worker_finish <= new_load;
            o_makespan      <= span;
            o_overflow      <= ovf;
        end
    end

    always_comb begin
        any_load = 1'b0;
        for (int w = 0; w < MAX_WORKERS; w++) begin
            any_load = any_load || (r_load[w] != '0);
        end
    end

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_last) |=> !any_load)
        else $error("loads not cleared after last task of job");

    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_worker_finish == {LOAD_BITS{1'b1}}))
        else $error("overflow without saturated load");

    a_span_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_makespan >= o_worker_finish))
        else $error("makespan below chosen worker finish");

    a_load_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && !i_q_last) |=> (o_worker_finish >= $past(t_min[IDX_W][0])))
        else $error("chosen load decreased");

endmodule

@@ rtl/least_loaded_task_assigner.sv @@
// least_loaded_task_assigner: a task item passes the task queue and then the
// scheduler's result register from task accept to result valid. Throughput
// 1 task per cycle while results are taken: the least-load tree, saturating
// add and makespan resolve combinationally, and the load table updates in place.
// Synchronous active-low reset: all loads zero, workers_in_use = 2, queue empty,
// no result pending. Depends on llta_pkg, llta_if, llta_front, llta_back.
module least_loaded_task_assigner #(
    parameter int MAX_WORKERS   = llta_pkg::DEF_MAX_WORKERS,
    parameter int DURATION_BITS = llta_pkg::DEF_DURATION_BITS,
    parameter int LOAD_BITS     = llta_pkg::DEF_LOAD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [llta_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [llta_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [llta_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // channels
    llta_task_if.sink                           i_task,
    llta_result_if.source                       o_result
);

    // ---------------------------------------------------------------
    // Configuration register. One register, workers_in_use, at byte
    // address 0; the word index is paddr[2], byte offset bits ignored.
    // Writes to any other word are dropped. Values 0 and above the
    // worker count are clamped inside the scheduler.
    // ---------------------------------------------------------------
    logic [llta_pkg::CFG_W-1:0] r_workers;
    llta_pkg::t_reg_idx         reg_idx;

    assign reg_idx = llta_pkg::t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_workers <= llta_pkg::WORKERS_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (reg_idx == llta_pkg::REG_WORKERS_IN_USE)) begin
            r_workers <= pwdata[llta_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        case (reg_idx)
            llta_pkg::REG_WORKERS_IN_USE:
                prdata = {{(llta_pkg::APB_DATA_W - llta_pkg::CFG_W){1'b0}}, r_workers};
            default:
                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Front: takes task items into a two-entry queue, so the input
    // side can still take items while a result waits on the output side.
    // ---------------------------------------------------------------
    logic                     q_valid;
    logic [DURATION_BITS-1:0] q_duration;
    logic                     q_last;
    logic                     q_pop;

    llta_front #(
        .DURATION_BITS (DURATION_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_task.valid),
        .o_ready      (i_task.ready),
        .i_duration   (i_task.duration),
        .i_last       (i_task.last_of_job),
        .o_q_valid    (q_valid),
        .o_q_duration (q_duration),
        .o_q_last     (q_last),
        .i_q_pop      (q_pop)
    );

    // ---------------------------------------------------------------
    // Back: picks the least loaded worker in use (lowest index wins a
    // tie), adds the duration with saturation, works out the makespan
    // and registers the result. A last-of-job item clears every load
    // once its result is formed, so the next item sees a fresh job.
    // ---------------------------------------------------------------
    llta_back #(
        .MAX_WORKERS   (MAX_WORKERS),
        .DURATION_BITS (DURATION_BITS),
        .LOAD_BITS     (LOAD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_workers       (r_workers),
        .i_q_valid       (q_valid),
        .i_q_duration    (q_duration),
        .i_q_last        (q_last),
        .o_q_pop         (q_pop),
        .o_valid         (o_result.valid),
        .i_ready         (o_result.ready),
        .o_chosen_worker (o_result.chosen_worker),
        .o_worker_finish (o_result.worker_finish),
        .o_makespan      (o_result.makespan),
        .o_overflow      (o_result.overflow)
    );

endmodule

@@ sim/llta_schedule_check.sv @@
`timescale 1ns / 100ps
// llta_schedule_check: watches the task, result and register traffic of the
// least loaded task assigner, predicts every assignment and compares results.
// Depends on llta_pkg.
module llta_schedule_check #(
    parameter int MAX_WORKERS   = llta_pkg::DEF_MAX_WORKERS,
    parameter int DURATION_BITS = llta_pkg::DEF_DURATION_BITS,
    parameter int LOAD_BITS     = llta_pkg::DEF_LOAD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [llta_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  logic [llta_pkg::APB_DATA_W-1:0]     i_pwdata,
    input  logic                                i_task_valid,
    input  logic                                i_task_ready,
    input  logic [DURATION_BITS-1:0]            i_task_duration,
    input  logic                                i_task_last,
    input  logic                                i_res_valid,
    input  logic                                i_res_ready,
    input  logic [llta_pkg::WORKER_FIELD_W-1:0] i_res_worker,
    input  logic [LOAD_BITS-1:0]                i_res_finish,
    input  logic [LOAD_BITS-1:0]                i_res_span,
    input  logic                                i_res_overflow,
    output int                                  o_fail_count,
    output int                                  o_outstanding
);

    typedef struct packed {
        logic [llta_pkg::WORKER_FIELD_W-1:0] worker;
        logic [LOAD_BITS-1:0]                finish;
        logic [LOAD_BITS-1:0]                span;
        logic                                overflow;
    } t_assignment;

    logic [LOAD_BITS-1:0]       worker_load [MAX_WORKERS];
    logic [llta_pkg::CFG_W-1:0] workers_cfg;
    t_assignment                pending_assignments [$];

    // greedy least-load choice, saturating add, makespan, clear on job end
    task automatic predict_assignment(input logic [DURATION_BITS-1:0] dur,
                                      input logic last, output t_assignment res);
        int                   n;
        int                   best;
        logic [LOAD_BITS:0]   sum;
        logic [LOAD_BITS-1:0] span;
        n = (workers_cfg == '0) ? 1 :
            (int'(workers_cfg) > MAX_WORKERS) ? MAX_WORKERS : int'(workers_cfg);
        best = 0;
        for (int w = 1; w < n; w++)
            if (worker_load[w] < worker_load[best]) best = w;
        sum = {1'b0, worker_load[best]} + (LOAD_BITS+1)'(dur);
        res.overflow = sum[LOAD_BITS];
        res.finish   = sum[LOAD_BITS] ? '1 : sum[LOAD_BITS-1:0];
        res.worker   = llta_pkg::WORKER_FIELD_W'(best);
        worker_load[best] = res.finish;
        span = '0;
        for (int w = 0; w < n; w++)
            if (worker_load[w] > span) span = worker_load[w];
        res.span = span;
        if (last)
            for (int w = 0; w < MAX_WORKERS; w++) worker_load[w] = '0;
    endtask

    always @(posedge i_clk) begin : watch
        int          errs;
        int          delta;
        t_assignment want;
        if (!i_rst_n) begin
            for (int w = 0; w < MAX_WORKERS; w++) worker_load[w] = '0;
            workers_cfg = llta_pkg::WORKERS_RESET;
            pending_assignments.delete();
            o_fail_count  <= 0;
            o_outstanding <= 0;
        end else begin
            errs  = 0;
            delta = 0;
            if (i_psel && i_penable && i_pwrite && i_pready &&
                llta_pkg::t_reg_idx'(i_paddr[2]) == llta_pkg::REG_WORKERS_IN_USE)
                workers_cfg = i_pwdata[llta_pkg::CFG_W-1:0];
            if (i_res_valid && i_res_ready) begin
                if (pending_assignments.size() == 0) begin
                    $error("result item with no task outstanding");
                    errs++;
                end else begin
                    want = pending_assignments.pop_front();
                    delta--;
                    if (i_res_worker !== want.worker) begin
                        $error("chosen_worker: expected %0d, got %0d",
                               want.worker, i_res_worker);
                        errs++;
                    end
                    if (i_res_finish !== want.finish) begin
                        $error("worker_finish: expected %0d, got %0d",
                               want.finish, i_res_finish);
                        errs++;
                    end
                    if (i_res_span !== want.span) begin
                        $error("makespan: expected %0d, got %0d", want.span, i_res_span);
                        errs++;
                    end
                    if (i_res_overflow !== want.overflow) begin
                        $error("overflow: expected %0d, got %0d",
                               want.overflow, i_res_overflow);
                        errs++;
                    end
                end
            end
            if (i_task_valid && i_task_ready) begin
                predict_assignment(i_task_duration, i_task_last, want);
                pending_assignments.push_back(want);
                delta++;
            end
            o_fail_count  <= o_fail_count + errs;
            o_outstanding <= o_outstanding + delta;
        end
    end

endmodule

@@ sim/least_loaded_task_assigner_tb.sv @@
`timescale 1ns / 100ps
// least_loaded_task_assigner_tb: drives tasks, register writes and result
// back-pressure into the assigner; llta_schedule_check does the checking.
// Depends on llta_pkg, llta_if, the rtl and llta_schedule_check.
module least_loaded_task_assigner_tb;

    localparam int DUR_W = llta_pkg::DEF_DURATION_BITS;
    localparam int LOAD_W = llta_pkg::DEF_LOAD_BITS;
    // slowest run: ~1100 items, each with random gaps on the task and result
    // sides, the pipeline latency and drains between phases; taken many times over
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 770;

    localparam logic [llta_pkg::APB_ADDR_W-1:0] ADDR_WORKERS =
        {llta_pkg::REG_WORKERS_IN_USE, 2'b00};
    localparam logic [llta_pkg::APB_ADDR_W-1:0] ADDR_SPARE   =
        {llta_pkg::REG_UNUSED, 2'b00};

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [llta_pkg::APB_ADDR_W-1:0] paddr;
    logic [llta_pkg::APB_DATA_W-1:0] pwdata;
    logic [llta_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    llta_task_if   #(.DURATION_BITS(DUR_W)) task_ch ();
    llta_result_if #(.LOAD_BITS(LOAD_W))    res_ch ();

    int   fail_count;
    int   outstanding;
    int   cycle_count = 0;
    int   tasks_sent = 0;
    int   writes_done = 0;
    int   result_stall;
    logic calm_sender;      // no gaps between task items
    logic calm_receiver;    // result ready held high

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    least_loaded_task_assigner dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_task   (task_ch),
        .o_result (res_ch)
    );

    llta_schedule_check #(
        .DURATION_BITS (DUR_W),
        .LOAD_BITS     (LOAD_W)
    ) u_schedule_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_task_valid    (task_ch.valid),
        .i_task_ready    (task_ch.ready),
        .i_task_duration (task_ch.duration),
        .i_task_last     (task_ch.last_of_job),
        .i_res_valid     (res_ch.valid),
        .i_res_ready     (res_ch.ready),
        .i_res_worker    (res_ch.chosen_worker),
        .i_res_finish    (res_ch.worker_finish),
        .i_res_span      (res_ch.makespan),
        .i_res_overflow  (res_ch.overflow),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    // result back-pressure: after each accepted item, ready may drop low for a
    // random stall before it rises again; calm stretches keep it high throughout
    always @(posedge i_clk) begin : result_sink
        int draw;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            result_stall <= 0;
        end else if (res_ch.valid && res_ch.ready) begin
            draw = calm_receiver ? 0 : $urandom_range(0, 15);
            result_stall <= draw;
            res_ch.ready <= (draw == 0);
        end else if (!res_ch.ready) begin
            if (result_stall <= 1) begin
                res_ch.ready <= 1'b1;
                result_stall <= 0;
            end else begin
                result_stall <= result_stall - 1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("status: fail");
            $finish;
        end
    end

    // one task item, after a random gap; returns at the accepting edge with
    // valid still high, so a back-to-back item needs no second assignment
    task automatic offer_task(input logic [DUR_W-1:0] dur, input logic last);
        int gap;
        gap = calm_sender ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            task_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        task_ch.valid       <= 1'b1;
        task_ch.duration    <= dur;
        task_ch.last_of_job <= last;
        do @(posedge i_clk); while (!task_ch.ready);
        tasks_sent++;
    endtask

    // block idle: every task answered, then a little margin for the pipeline
    task automatic wait_for_results_idle();
        task_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // setup phase, access phase, then the bus is released before the task returns
    task automatic write_register(input logic [llta_pkg::APB_ADDR_W-1:0] addr,
                                  input logic [llta_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        writes_done++;
    endtask

    // one job: style 0 is largest-first (the intended use), 1 full range,
    // 2 tiny durations (many ties), 3 near the top of the range.
    // An occasional stray end-of-job mark lands mid-job as noise.
    task automatic run_job(input int len, input int style, input logic close);
        logic [DUR_W-1:0] next_dur;
        logic [DUR_W-1:0] dur;
        logic             last;
        int               step;
        int               pick;
        next_dur = DUR_W'($urandom_range(0, 65535));
        step     = $urandom_range(0, 4000);
        for (int i = 0; i < len; i++) begin
            case (style)
                0: begin
                    dur  = next_dur;
                    pick = $urandom_range(0, step);
                    next_dur = (int'(next_dur) > pick) ? next_dur - DUR_W'(pick) : '0;
                end
                1: dur = DUR_W'($urandom_range(0, 65535));
                2: dur = DUR_W'($urandom_range(0, 15));
                default: dur = DUR_W'($urandom_range(65000, 65535));
            endcase
            last = (i == len - 1) ? close : ($urandom_range(0, 24) == 0);
            offer_task(dur, last);
        end
    endtask

    initial begin : stimulus
        int rand_start;
        int style_draw;
        int cfg_draw;
        int cfg;
        task_ch.valid       = 1'b0;
        task_ch.duration    = '0;
        task_ch.last_of_job = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        calm_sender         = 1'b0;
        calm_receiver       = 1'b0;
        i_rst_n             = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset setting of two workers, zero-duration ties,
        // full-range durations, end of job
        offer_task(16'd0, 1'b0);
        offer_task(16'd0, 1'b0);
        offer_task(16'hFFFF, 1'b0);
        offer_task(16'd1, 1'b0);
        offer_task(16'd100, 1'b0);
        offer_task(16'hFFFF, 1'b1);

        // write to the spare address must leave two workers in place
        wait_for_results_idle();
        write_register(ADDR_SPARE, 32'd1);
        offer_task(16'd5, 1'b0);
        offer_task(16'd5, 1'b1);

        // zero workers behaves as one
        wait_for_results_idle();
        write_register(ADDR_WORKERS, 32'd0);
        offer_task(16'd7, 1'b0);
        offer_task(16'hFFFF, 1'b1);

        // above the maximum behaves as sixteen
        wait_for_results_idle();
        write_register(ADDR_WORKERS, 32'd31);
        offer_task(16'd30, 1'b0);
        offer_task(16'd20, 1'b0);
        offer_task(16'd20, 1'b0);
        offer_task(16'd1, 1'b1);

        // idle workers: load four, shrink to two, grow back to four; the
        // loads of workers two and three must survive untouched
        wait_for_results_idle();
        write_register(ADDR_WORKERS, 32'd4);
        offer_task(16'd10, 1'b0);
        offer_task(16'd20, 1'b0);
        offer_task(16'd30, 1'b0);
        offer_task(16'd40, 1'b0);
        wait_for_results_idle();
        write_register(ADDR_WORKERS, 32'd2);
        offer_task(16'd1, 1'b0);
        offer_task(16'd1, 1'b0);
        wait_for_results_idle();
        write_register(ADDR_WORKERS, 32'd4);
        offer_task(16'd3, 1'b1);

        // saturation on a single worker: 256 full tasks leave 255 of headroom,
        // 255 lands exactly on the ceiling, then 1 and a full task overflow
        wait_for_results_idle();
        write_register(ADDR_WORKERS, 32'd1);
        calm_sender   = 1'b1;
        calm_receiver <= 1'b1;
        for (int i = 0; i < 256; i++) offer_task(16'hFFFF, 1'b0);
        calm_sender   = 1'b0;
        calm_receiver <= 1'b0;
        offer_task(16'd255, 1'b0);
        offer_task(16'd1, 1'b0);
        offer_task(16'hFFFF, 1'b1);

        // random phases: a worker count, then a few jobs at that setting
        rand_start = tasks_sent;
        while (tasks_sent - rand_start < RANDOM_ITEMS) begin
            wait_for_results_idle();
            cfg_draw = $urandom_range(0, 9);
            case (cfg_draw)
                0: cfg = 1;
                1: cfg = 16;
                2: cfg = 0;
                3: cfg = 31;
                4: cfg = $urandom_range(17, 31);
                default: cfg = $urandom_range(1, 16);
            endcase
            if ($urandom_range(0, 9) == 0)
                write_register(ADDR_SPARE, $urandom_range(0, 31));
            write_register(ADDR_WORKERS, llta_pkg::APB_DATA_W'(cfg));
            repeat ($urandom_range(1, 4)) begin
                calm_sender   = ($urandom_range(0, 3) == 0);
                calm_receiver <= ($urandom_range(0, 3) == 0);
                style_draw = $urandom_range(0, 19);
                run_job($urandom_range(1, 40),
                        (style_draw < 10) ? 0 : (style_draw < 15) ? 1 :
                        (style_draw < 18) ? 2 : 3,
                        ($urandom_range(0, 9) != 0));
            end
        end

        calm_receiver <= 1'b0;
        wait_for_results_idle();
        repeat (4) @(posedge i_clk);

        $display("%0d tasks over %0d register writes: ties, saturation, idle workers,",
                 tasks_sent, writes_done);
        $display("out-of-range worker counts and largest-first jobs under random stalls");
        if (fail_count == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
